/* rtl/rrd_pkg.sv */
`timescale 1ns / 1ps

package rrd_pkg;

  // payload field widths
  localparam int MODE_W   = 2;
  localparam int TID_W    = 15;
  localparam int ST_W     = 8;
  localparam int RND_W    = 16;
  localparam int MSG_W    = 32;
  localparam int STATUS_W = 3;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEND = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

  // state byte of an open target
  localparam logic [ST_W-1:0] TGT_ST_OPEN = 8'd0;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_SCAN,
    S_RR_SCAN,
    S_CNT_SCAN,
    S_DIV,
    S_PICK_SCAN,
    S_EMIT
  } rrd_fsm_e;

endpackage

/* rtl/rrd_req_if.sv */
`timescale 1ns / 1ps

interface rrd_req_if;
  import rrd_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [TID_W-1:0]   target_id;
  logic [ST_W-1:0]    new_state;
  logic [RND_W-1:0]   random_value;
  logic [MSG_W-1:0]   message_word;

  modport source (
    output valid, mode, target_id, new_state, random_value, message_word,
    input  ready
  );

  modport sink (
    input  valid, mode, target_id, new_state, random_value, message_word,
    output ready
  );

endinterface

/* rtl/rrd_rsp_if.sv */
`timescale 1ns / 1ps

interface rrd_rsp_if;
  import rrd_pkg::*;

  logic                valid;
  logic                ready;
  logic                send_valid;
  logic [TID_W-1:0]    dest_id;
  logic [STATUS_W-1:0] status;
  logic [MSG_W-1:0]    message_out;

  modport source (
    output valid, send_valid, dest_id, status, message_out,
    input  ready
  );

  modport sink (
    input  valid, send_valid, dest_id, status, message_out,
    output ready
  );

endinterface

/* rtl/rrd_table.sv */
`timescale 1ns / 1ps

module rrd_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                     clk_i,
  input  logic                     tgt_we_i,
  input  logic [IDX_W-1:0]         tgt_waddr_i,
  input  logic [rrd_pkg::TID_W-1:0] tgt_wdata_i,
  input  logic                     st_we_i,
  input  logic [IDX_W-1:0]         st_waddr_i,
  input  logic [rrd_pkg::ST_W-1:0]  st_wdata_i,
  input  logic                     re_i,
  input  logic [IDX_W-1:0]         raddr_i,
  output logic [rrd_pkg::TID_W-1:0] rd_tgt_o,
  output logic [rrd_pkg::ST_W-1:0]  rd_st_o
);
  import rrd_pkg::*;

  logic [TID_W-1:0] tgt_mem [DEPTH];
  logic [ST_W-1:0]  st_mem  [DEPTH];

  // target id memory
  always_ff @(posedge clk_i) begin
    if (tgt_we_i) begin
      tgt_mem[tgt_waddr_i] <= tgt_wdata_i;
    end
    if (re_i) begin
      rd_tgt_o <= tgt_mem[raddr_i];
    end
  end

  // state byte memory
  always_ff @(posedge clk_i) begin
    if (st_we_i) begin
      st_mem[st_waddr_i] <= st_wdata_i;
    end
    if (re_i) begin
      rd_st_o <= st_mem[raddr_i];
    end
  end

endmodule

/* rtl/rrd_rem.sv */
`timescale 1ns / 1ps

module rrd_rem #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVISOR_W-1:0]  rem_o
);
  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] shf_q, shf_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, shf_q[DIVIDEND_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIVIDEND_W);
      shf_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIVISOR_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
      shf_d = {shf_q[DIVIDEND_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    shf_q <= shf_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/round_robin_dispatch_skip_blocked.sv */
`timescale 1ns / 1ps

// Message dispatcher over a table of up to MAX_TARGETS target ids.
// req_i carries one transaction per item: load a target, set the state
// byte of a sender, or dispatch a message word. rsp_o returns exactly one
// result transaction per item, in order. cfg_we_i/cfg_wdata_i write the
// pick policy (0 round robin over open targets, 1 random among open).
// Items are handled one at a time; the table lives in a synchronous memory
// read one entry per cycle. A load, an unused mode or an empty table
// goes straight to the result; set state and round robin dispatch scan
// the loaded entries; random dispatch counts the open entries, takes the
// random value modulo that count in a bit-serial remainder unit, then
// scans the table again for the chosen open entry.
// A result waits in an output register; the next request is taken while
// it waits, but that item cannot finish until the receiver takes the
// earlier result. Reset empties the table, clears the round robin pointer
// and the policy, and drops any pending result; no clearing pass is run.
module round_robin_dispatch_skip_blocked #(
  parameter int MAX_TARGETS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  rrd_req_if.sink    req_i,
  rrd_rsp_if.source  rsp_o
);
  import rrd_pkg::*;

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_TARGETS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_TARGETS);

  rrd_fsm_e state_q, state_d;

  logic              policy_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;

  // latched item
  logic [TID_W-1:0]  tid_q, tid_d;
  logic [ST_W-1:0]   nst_q, nst_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic [MSG_W-1:0]  msg_q, msg_d;

  // pending result
  logic                res_send_q, res_send_d;
  logic [TID_W-1:0]    res_dest_q, res_dest_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  // output register
  logic                out_vld_q, out_vld_d;
  logic                out_send_q, out_send_d;
  logic [TID_W-1:0]    out_dest_q, out_dest_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [MSG_W-1:0]    out_msg_q, out_msg_d;

  // scan pipeline
  logic [IDX_W-1:0]  iss_idx_q, iss_idx_d;
  logic [CNT_W-1:0]  iss_rem_q, iss_rem_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              chk_last_q, chk_last_d;
  logic [CNT_W-1:0]  opens_q, opens_d;
  logic [CNT_W-1:0]  pick_q, pick_d;

  logic              req_accept;
  logic              out_free;
  logic              full;
  logic              scanning;
  logic              stop;
  logic              issue;
  logic              rd_open;
  logic              tid_hit;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  last_idx;
  logic [CNT_W-1:0]  ptr_ext;
  logic [CNT_W-1:0]  ptr_red;
  logic [IDX_W-1:0]  iss_next;
  logic [IDX_W-1:0]  chk_next;
  logic [CNT_W-1:0]  opens_sum;

  logic              tgt_we;
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [ST_W-1:0]   st_wdata;
  logic [TID_W-1:0]  rd_tgt;
  logic [ST_W-1:0]   rd_st;
  logic              div_start;
  logic              div_done;
  logic [CNT_W-1:0]  div_rem;

  // handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;

  // table geometry and index arithmetic
  assign full     = (count_q == FULL_CNT);
  assign cnt_m1   = count_q - 1'b1;
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign ptr_ext  = CNT_W'(ptr_q);
  assign ptr_red  = (ptr_ext >= count_q) ? (ptr_ext - count_q) : ptr_ext;
  assign iss_next = (iss_idx_q == last_idx) ? '0 : iss_idx_q + 1'b1;
  assign chk_next = (chk_idx_q == LAST_SLOT) ? '0 : chk_idx_q + 1'b1;

  // checks on the entry read last cycle
  assign rd_open   = (rd_st == TGT_ST_OPEN);
  assign tid_hit   = (rd_tgt == tid_q);
  assign opens_sum = opens_q + CNT_W'(rd_open);

  assign scanning = (state_q == S_SET_SCAN) || (state_q == S_RR_SCAN) ||
                    (state_q == S_CNT_SCAN) || (state_q == S_PICK_SCAN);

  // scan end condition per state
  always_comb begin
    case (state_q)
      S_SET_SCAN:  stop = chk_vld_q && (tid_hit || chk_last_q);
      S_RR_SCAN:   stop = chk_vld_q && (rd_open || chk_last_q);
      S_CNT_SCAN:  stop = chk_vld_q && chk_last_q;
      S_PICK_SCAN: stop = chk_vld_q && rd_open && (pick_q == '0);
      default:     stop = 1'b0;
    endcase
  end

  assign issue = scanning && (iss_rem_q != '0) && !stop;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          case (req_i.mode)
            MODE_SET: begin
              state_d = (count_q == '0) ? S_EMIT : S_SET_SCAN;
            end
            MODE_SEND: begin
              if (count_q == '0) begin
                state_d = S_EMIT;
              end else begin
                state_d = policy_q ? S_CNT_SCAN : S_RR_SCAN;
              end
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_SET_SCAN, S_RR_SCAN, S_PICK_SCAN: begin
        if (stop) begin
          state_d = S_EMIT;
        end
      end
      S_CNT_SCAN: begin
        if (stop) begin
          state_d = (opens_sum == '0) ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_PICK_SCAN;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    tid_d        = tid_q;
    nst_d        = nst_q;
    rnd_d        = rnd_q;
    msg_d        = msg_q;
    res_send_d   = res_send_q;
    res_dest_d   = res_dest_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q;
    out_send_d   = out_send_q;
    out_dest_d   = out_dest_q;
    out_status_d = out_status_q;
    out_msg_d    = out_msg_q;
    iss_idx_d    = iss_idx_q;
    iss_rem_d    = iss_rem_q;
    chk_vld_d    = issue;
    chk_idx_d    = chk_idx_q;
    chk_last_d   = chk_last_q;
    opens_d      = opens_q;
    pick_d       = pick_q;
    tgt_we       = 1'b0;
    st_we        = 1'b0;
    st_waddr     = count_q[IDX_W-1:0];
    st_wdata     = TGT_ST_OPEN;
    div_start    = 1'b0;

    // result taken by the receiver
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    // issue one table read per cycle
    if (issue) begin
      iss_idx_d  = iss_next;
      iss_rem_d  = iss_rem_q - 1'b1;
      chk_idx_d  = iss_idx_q;
      chk_last_d = (iss_rem_q == CNT_W'(1));
    end

    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          tid_d        = req_i.target_id;
          nst_d        = req_i.new_state;
          rnd_d        = req_i.random_value;
          msg_d        = req_i.message_word;
          res_send_d   = 1'b0;
          res_dest_d   = '0;
          res_status_d = STATUS_OK;
          iss_idx_d    = '0;
          iss_rem_d    = count_q;
          opens_d      = '0;
          case (req_i.mode)
            MODE_LOAD: begin
              if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                tgt_we  = 1'b1;
                st_we   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            MODE_SET: begin
              if (count_q == '0) begin
                res_status_d = STATUS_UNKNOWN;
              end
            end
            MODE_SEND: begin
              if (count_q == '0) begin
                res_status_d = STATUS_EMPTY;
              end else if (!policy_q) begin
                iss_idx_d = ptr_red[IDX_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_SET_SCAN: begin
        if (chk_vld_q) begin
          if (tid_hit) begin
            st_we        = 1'b1;
            st_waddr     = chk_idx_q;
            st_wdata     = nst_q;
            res_status_d = STATUS_OK;
          end else if (chk_last_q) begin
            res_status_d = STATUS_UNKNOWN;
          end
        end
      end
      S_RR_SCAN: begin
        if (stop) begin
          res_send_d   = 1'b1;
          res_dest_d   = rd_tgt;
          res_status_d = rd_open ? STATUS_OK : STATUS_BLOCKED;
          ptr_d        = chk_next;
        end
      end
      S_CNT_SCAN: begin
        if (chk_vld_q) begin
          opens_d = opens_sum;
          if (chk_last_q) begin
            if (opens_sum == '0) begin
              res_send_d   = 1'b1;
              res_dest_d   = '0;
              res_status_d = STATUS_BLOCKED;
            end else begin
              div_start = 1'b1;
              iss_idx_d = '0;
              iss_rem_d = count_q;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          pick_d = div_rem;
        end
      end
      S_PICK_SCAN: begin
        if (chk_vld_q && rd_open) begin
          if (pick_q == '0) begin
            res_send_d   = 1'b1;
            res_dest_d   = rd_tgt;
            res_status_d = STATUS_OK;
          end else begin
            pick_d = pick_q - 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_send_d   = res_send_q;
          out_dest_d   = res_dest_q;
          out_status_d = res_status_q;
          out_msg_d    = res_send_q ? msg_q : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      policy_q  <= 1'b0;
      count_q   <= '0;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
      chk_vld_q <= chk_vld_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tid_q        <= tid_d;
    nst_q        <= nst_d;
    rnd_q        <= rnd_d;
    msg_q        <= msg_d;
    res_send_q   <= res_send_d;
    res_dest_q   <= res_dest_d;
    res_status_q <= res_status_d;
    out_send_q   <= out_send_d;
    out_dest_q   <= out_dest_d;
    out_status_q <= out_status_d;
    out_msg_q    <= out_msg_d;
    iss_idx_q    <= iss_idx_d;
    iss_rem_q    <= iss_rem_d;
    chk_idx_q    <= chk_idx_d;
    chk_last_q   <= chk_last_d;
    opens_q      <= opens_d;
    pick_q       <= pick_d;
  end

  // target and state memories
  rrd_table #(
    .DEPTH (MAX_TARGETS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i       (clk_i),
    .tgt_we_i    (tgt_we),
    .tgt_waddr_i (count_q[IDX_W-1:0]),
    .tgt_wdata_i (req_i.target_id),
    .st_we_i     (st_we),
    .st_waddr_i  (st_waddr),
    .st_wdata_i  (st_wdata),
    .re_i        (issue),
    .raddr_i     (iss_idx_q),
    .rd_tgt_o    (rd_tgt),
    .rd_st_o     (rd_st)
  );

  // random value modulo open count
  rrd_rem #(
    .DIVIDEND_W (RND_W),
    .DIVISOR_W  (CNT_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (opens_sum),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // result channel
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.send_valid  = out_send_q;
  assign rsp_o.dest_id     = out_dest_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.message_out = out_msg_q;

endmodule

/* rtl/rrd_checker.sv */
`timescale 1ns / 1ps

module rrd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          send_valid_i,
  input logic [rrd_pkg::TID_W-1:0]     dest_id_i,
  input logic [rrd_pkg::STATUS_W-1:0]  status_i,
  input logic [rrd_pkg::MSG_W-1:0]     message_out_i
);
  import rrd_pkg::*;

  // stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(send_valid_i) && $stable(dest_id_i) &&
      $stable(status_i) && $stable(message_out_i))
    else $error("result payload changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an item is in work");

  // no message forwarded means zero destination and payload
  a_no_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !send_valid_i |-> dest_id_i == '0 && message_out_i == '0)
    else $error("non-forwarding result carries data");

  // all-blocked dispatch still forwards
  a_blocked_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == STATUS_BLOCKED |-> send_valid_i)
    else $error("all-blocked result without forwarding");

endmodule

bind round_robin_dispatch_skip_blocked rrd_checker u_rrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .send_valid_i  (rsp_o.send_valid),
  .dest_id_i     (rsp_o.dest_id),
  .status_i      (rsp_o.status),
  .message_out_i (rsp_o.message_out)
);

/* tb/round_robin_dispatch_skip_blocked_test.sv */
`timescale 1ns / 1ps

module round_robin_dispatch_skip_blocked_test;
  import rrd_pkg::*;

  localparam int MAX_TGT = 16;
  // highest table fill reached before the duplicate id test
  localparam int DISTINCT_CAP = MAX_TGT - 1;
  // longest item (random pick over a full table) plus margin
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int REPORT_LIMIT = 10;

  // item kind with no function in the block
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // pick policy register values
  localparam logic POLICY_RR     = 1'b0;
  localparam logic POLICY_RANDOM = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TID_W-1:0]  target_id;
    logic [ST_W-1:0]   new_state;
    logic [RND_W-1:0]  random_value;
    logic [MSG_W-1:0]  message_word;
  } dispatch_req_t;

  typedef struct packed {
    logic                send_valid;
    logic [TID_W-1:0]    dest_id;
    logic [STATUS_W-1:0] status;
    logic [MSG_W-1:0]    message_out;
  } route_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  rrd_req_if req_if ();
  rrd_rsp_if rsp_if ();

  round_robin_dispatch_skip_blocked #(
    .MAX_TARGETS(MAX_TGT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow copy of the dispatcher state
  logic [TID_W-1:0] tgt_ids [MAX_TGT];
  logic [ST_W-1:0]  tgt_state [MAX_TGT];
  int unsigned      tgt_count;
  logic [3:0]       rr_ptr;
  logic             pick_policy;

  route_t pending_routes [$];
  int     mismatches;
  int     cycle_count;
  int     rsp_hold_cycles;
  bit     req_idle_en;
  bit     rsp_idle_en;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_routes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // expected outcome of one item; updates the shadow state
  function automatic route_t predict_route(input dispatch_req_t it);
    route_t      r;
    int unsigned n, idx, last, k, open_cnt, pick, seen, chosen;
    bit          hit;
    r = '0;
    n = tgt_count;
    case (it.mode)
      MODE_LOAD: begin
        if (n >= MAX_TGT) begin
          r.status = STATUS_FULL;
        end else begin
          tgt_ids[n]   = it.target_id;
          tgt_state[n] = TGT_ST_OPEN;
          tgt_count    = n + 1;
          r.status     = STATUS_OK;
        end
      end
      MODE_SET: begin
        // only the first matching entry is updated
        hit = 1'b0;
        for (k = 0; k < n; k++) begin
          if (!hit && tgt_ids[k] == it.target_id) begin
            tgt_state[k] = it.new_state;
            hit = 1'b1;
          end
        end
        r.status = hit ? STATUS_OK : STATUS_UNKNOWN;
      end
      MODE_SEND: begin
        if (n == 0) begin
          r.status = STATUS_EMPTY;
        end else if (pick_policy == POLICY_RR) begin
          // walk from the pointer, skipping blocked entries
          idx = rr_ptr % n;
          hit = 1'b0;
          for (k = 0; k < n; k++) begin
            if (!hit) begin
              r.dest_id = tgt_ids[idx];
              if (tgt_state[idx] == TGT_ST_OPEN) hit = 1'b1;
              else idx = (idx + 1) % n;
            end
          end
          if (hit) begin
            rr_ptr = 4'((idx + 1) % MAX_TGT);
          end else begin
            last   = (idx + n - 1) % n;
            rr_ptr = 4'((last + 1) % MAX_TGT);
          end
          r.send_valid  = 1'b1;
          r.status      = hit ? STATUS_OK : STATUS_BLOCKED;
          r.message_out = it.message_word;
        end else begin
          // random choice among open entries
          open_cnt = 0;
          for (k = 0; k < n; k++) begin
            if (tgt_state[k] == TGT_ST_OPEN) open_cnt++;
          end
          r.send_valid  = 1'b1;
          r.message_out = it.message_word;
          if (open_cnt == 0) begin
            r.dest_id = '0;
            r.status  = STATUS_BLOCKED;
          end else begin
            pick   = it.random_value % open_cnt;
            seen   = 0;
            chosen = 0;
            for (k = 0; k < n; k++) begin
              if (tgt_state[k] == TGT_ST_OPEN) begin
                if (seen == pick) chosen = k;
                seen++;
              end
            end
            r.dest_id = tgt_ids[chosen];
            r.status  = STATUS_OK;
          end
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic dispatch_req_t make_req(input logic [MODE_W-1:0] mode,
                                             input logic [TID_W-1:0] tid,
                                             input logic [ST_W-1:0] nst,
                                             input logic [RND_W-1:0] rnd,
                                             input logic [MSG_W-1:0] msg);
    dispatch_req_t it;
    it.mode         = mode;
    it.target_id    = tid;
    it.new_state    = nst;
    it.random_value = rnd;
    it.message_word = msg;
    return it;
  endfunction

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit id_loaded(input logic [TID_W-1:0] tid);
    bit found;
    found = 1'b0;
    for (int k = 0; k < tgt_count; k++) begin
      if (tgt_ids[k] == tid) found = 1'b1;
    end
    return found;
  endfunction

  // random item: mostly sets on loaded senders and dispatches
  function automatic dispatch_req_t random_req(input int load_pct, input int block_pct,
                                               input int load_cap);
    dispatch_req_t it;
    int            roll;
    it.mode         = MODE_SEND;
    it.target_id    = TID_W'($urandom_range(0, 32767));
    it.new_state    = ST_W'($urandom_range(0, 255));
    it.random_value = RND_W'($urandom_range(0, 65535));
    it.message_word = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < load_pct) begin
      if (tgt_count < load_cap) begin
        it.mode = MODE_LOAD;
        // keep ids distinct until the table is full
        while (tgt_count < MAX_TGT && id_loaded(it.target_id)) begin
          it.target_id = TID_W'($urandom_range(0, 32767));
        end
      end
    end else if (roll < load_pct + 3) begin
      it.mode = MODE_UNUSED;
    end else if (roll < 42) begin
      it.mode = MODE_SET;
      if (tgt_count > 0 && $urandom_range(0, 99) < 85) begin
        it.target_id = tgt_ids[$urandom_range(0, tgt_count - 1)];
      end
      if ($urandom_range(0, 99) < block_pct) begin
        it.new_state = ($urandom_range(0, 7) == 0) ? 8'hFF : ST_W'($urandom_range(1, 255));
      end else begin
        it.new_state = TGT_ST_OPEN;
      end
    end
    return it;
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic send_item(input dispatch_req_t it);
    int gap;
    gap = (req_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
    end
    @(negedge clk_i);
    req_if.valid        = 1'b1;
    req_if.mode         = it.mode;
    req_if.target_id    = it.target_id;
    req_if.new_state    = it.new_state;
    req_if.random_value = it.random_value;
    req_if.message_word = it.message_word;
    do @(posedge clk_i); while (!req_if.ready);
    pending_routes.push_back(predict_route(it));
  endtask

  // stop offering and wait for all results to come back
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait (pending_routes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_policy(input logic p);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = p;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    pick_policy = p;
  endtask

  task automatic run_phase(input logic p, input int load_pct, input int block_pct,
                           input int load_cap, input bit req_idle, input bit rsp_idle,
                           input int count);
    set_policy(p);
    req_idle_en = req_idle;
    rsp_idle_en = rsp_idle;
    repeat (count) send_item(random_req(load_pct, block_pct, load_cap));
    drain();
  endtask

  // result transaction checker
  always @(posedge clk_i) begin
    route_t got;
    route_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.send_valid  = rsp_if.send_valid;
      got.dest_id     = rsp_if.dest_id;
      got.status      = rsp_if.status;
      got.message_out = rsp_if.message_out;
      if (pending_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result send=%0b dest=%h status=%0d msg=%h",
                   $time, got.send_valid, got.dest_id, got.status, got.message_out);
      end else begin
        want = pending_routes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: exp send=%0b dest=%h st=%0d msg=%h, got send=%0b dest=%h st=%0d msg=%h",
                     $time, want.send_valid, want.dest_id, want.status, want.message_out,
                     got.send_valid, got.dest_id, got.status, got.message_out);
        end
      end
    end
  end

  // result ready with random gaps and requested hold-offs
  initial begin
    int gap;
    gap = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready = 1'b0;
        rsp_hold_cycles--;
      end else if (gap > 0) begin
        rsp_if.ready = 1'b0;
        gap--;
      end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
        gap = idle_len() - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // dispatch, set and unused items before any target is loaded
  task automatic test_empty_table();
    send_item(make_req(MODE_SEND, 15'h0001, 8'h00, 16'h0000, 32'hDEADBEEF));
    send_item(make_req(MODE_SET, 15'h0005, 8'hFF, 16'hFFFF, 32'h0));
    send_item(make_req(MODE_UNUSED, 15'h7FFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF));
    drain();
  endtask

  // round robin: skip blocked, wrap past the table end, all blocked
  task automatic test_round_robin_skip();
    send_item(make_req(MODE_LOAD, 15'h0000, 8'hFF, 16'h0, 32'h0));
    send_item(make_req(MODE_LOAD, 15'h7FFF, 8'h00, 16'h0, 32'h0));
    send_item(make_req(MODE_LOAD, 15'h2AAA, 8'h00, 16'h0, 32'h0));
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'h0, 32'hFFFFFFFF));
    send_item(make_req(MODE_SET, 15'h7FFF, 8'hFF, 16'h0, 32'h0));
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'h0, 32'h00000000));
    // pointer now equals the table size
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'h0, 32'h55555555));
    send_item(make_req(MODE_SET, 15'h0000, 8'h01, 16'h0, 32'h0));
    send_item(make_req(MODE_SET, 15'h2AAA, 8'h80, 16'h0, 32'h0));
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'h0, 32'hAAAAAAAA));
    send_item(make_req(MODE_SET, 15'h5555, 8'h00, 16'h0, 32'h0));
    drain();
  endtask

  // random policy: none open, lowest and highest random values
  task automatic test_random_pick();
    set_policy(POLICY_RANDOM);
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'hFFFF, 32'h12345678));
    send_item(make_req(MODE_SET, 15'h7FFF, 8'h00, 16'h0, 32'h0));
    send_item(make_req(MODE_SET, 15'h0000, 8'h00, 16'h0, 32'h0));
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'h0000, 32'h87654321));
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'hFFFF, 32'hFFFFFFFF));
    send_item(make_req(MODE_UNUSED, 15'h1234, 8'h56, 16'h789A, 32'hBCDEF012));
    drain();
  endtask

  // random traffic while the table grows with distinct ids
  task automatic test_mixed_traffic();
    run_phase(POLICY_RR,     2, 30, DISTINCT_CAP, 1'b1, 1'b1, 250);
    run_phase(POLICY_RANDOM, 2, 50, DISTINCT_CAP, 1'b1, 1'b0, 250);
    run_phase(POLICY_RR,     3, 95, DISTINCT_CAP, 1'b0, 1'b1, 250);
    run_phase(POLICY_RANDOM, 3, 90, DISTINCT_CAP, 1'b1, 1'b1, 250);
    run_phase(POLICY_RR,     2, 50, DISTINCT_CAP, 1'b0, 1'b0, 150);
  endtask

  // long result hold-off so the input stalls, then again with sender idle gaps
  task automatic test_output_stall();
    set_policy(POLICY_RANDOM);
    req_idle_en = 1'b0;
    rsp_idle_en = 1'b1;
    rsp_hold_cycles = 300;
    repeat (40) send_item(random_req(0, 40, DISTINCT_CAP));
    drain();
    req_idle_en = 1'b1;
    repeat (40) send_item(random_req(0, 40, DISTINCT_CAP));
    drain();
  endtask

  // last slot takes a duplicate id, then a load finds the table full
  task automatic test_duplicates_and_full();
    logic [TID_W-1:0] dup_id;
    set_policy(POLICY_RR);
    while (tgt_count < DISTINCT_CAP) begin
      send_item(random_req(100, 0, DISTINCT_CAP));
    end
    dup_id = tgt_ids[$urandom_range(0, tgt_count - 1)];
    send_item(make_req(MODE_LOAD, dup_id, 8'h00, 16'h0, 32'h0));
    send_item(make_req(MODE_SET, dup_id, 8'hFF, 16'h0, 32'h0));
    send_item(make_req(MODE_SEND, 15'h0, 8'h0, 16'h0, 32'h0F0F0F0F));
    send_item(make_req(MODE_LOAD, 15'h7FFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF));
    send_item(make_req(MODE_SET, dup_id, 8'h00, 16'h0, 32'h0));
    drain();
  endtask

  // random traffic on a full table
  task automatic test_full_table_traffic();
    run_phase(POLICY_RANDOM, 4, 60, MAX_TGT + 1, 1'b1, 1'b1, 175);
    run_phase(POLICY_RR,     4, 70, MAX_TGT + 1, 1'b1, 1'b1, 175);
  endtask

  // reset and test sequence
  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = 1'b0;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_LOAD;
    req_if.target_id    = '0;
    req_if.new_state    = '0;
    req_if.random_value = '0;
    req_if.message_word = '0;
    tgt_count       = 0;
    rr_ptr          = '0;
    pick_policy     = POLICY_RR;
    mismatches      = 0;
    cycle_count     = 0;
    rsp_hold_cycles = 0;
    req_idle_en     = 1'b1;
    rsp_idle_en     = 1'b1;
    for (int k = 0; k < MAX_TGT; k++) begin
      tgt_ids[k]   = '0;
      tgt_state[k] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_round_robin_skip();
    test_random_pick();
    test_mixed_traffic();
    test_output_stall();
    test_duplicates_and_full();
    test_full_table_traffic();

    drain();
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
